// ===== src/quadratic_root_solver_core_assert.svh =====
// Assertion macros used by the back end of the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QRS_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

// ===== src/qrs_pkg.sv =====
// Types and constants of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DISC_WIDTH = 2 * COEF_WIDTH + 2;
    localparam int SQRT_WIDTH = DISC_WIDTH / 2;
    localparam int NUM_WIDTH  = COEF_WIDTH + 3;
    localparam int DVD_WIDTH  = COEF_WIDTH + 2 + FRAC_BITS;
    localparam int DEN_WIDTH  = COEF_WIDTH + 1;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_square;
        logic signed [COEF_WIDTH-1:0] coef_linear;
        logic signed [COEF_WIDTH-1:0] coef_const;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                   root_count;
        logic signed [COEF_WIDTH-1:0] first_root;
        logic signed [COEF_WIDTH-1:0] second_root;
        logic                         saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        K_NONE,
        K_LIN,
        K_DBL,
        K_TWO
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic [DISC_WIDTH-1:0]       disc;
        logic signed [NUM_WIDTH-1:0] nbase;
        logic [DEN_WIDTH-1:0]        den;
        logic                        den_neg;
    } t_job;

    typedef struct packed {
        t_job                  job;
        logic [SQRT_WIDTH+1:0] rem;
        logic [SQRT_WIDTH-1:0] root;
        logic [DISC_WIDTH-1:0] rad;
    } t_sq;

    typedef struct packed {
        logic [DVD_WIDTH-1:0] dvd;
        logic [DEN_WIDTH-1:0] rem;
        logic [DVD_WIDTH-1:0] quo;
        logic                 neg;
    } t_lane;

    typedef struct packed {
        t_kind                kind;
        logic [DEN_WIDTH-1:0] den;
        t_lane                l0;
        t_lane                l1;
    } t_dv;

endpackage

// ===== src/quadratic_root_solver_core.sv =====
// Top level of the quadratic root solver.
// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients and returns the real root
// count with up to two Q16.16 roots, rounded toward zero and clipped with a flag. One
// item is accepted per cycle and one result leaves per cycle while results are taken;
// the path runs through two front stages for decode and the 32 by 32 products, the item
// queue, a 33 stage square root pipeline, one numerator stage, a 50 stage divider
// pipeline and the result register. When results are not taken, the back end holds, the
// four entry queue fills and full rises.
`timescale 1ns / 1ps
module quadratic_root_solver_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  qrs_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output qrs_pkg::t_out_item o_item
);
    import qrs_pkg::*;

    logic q_push, q_full, q_pop, q_empty, b_valid;
    t_job q_in, q_out;

    qrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_job_push (q_push),
        .o_job      (q_in),
        .i_job_full (q_full)
    );

    qrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    qrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_out),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .o_item      (o_item),
        .o_valid     (b_valid),
        .i_pop       (pop)
    );

    assign empty = !b_valid;

endmodule

// ===== src/qrs_front.sv =====
// Front end: decodes coefficients, forms the discriminant and classifies each item.
`timescale 1ns / 1ps
module qrs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  qrs_pkg::t_in_item i_item,
    output logic             o_job_push,
    output qrs_pkg::t_job    o_job,
    input  logic             i_job_full
);
    import qrs_pkg::*;

    logic                        r1_v, r2_v;
    logic [COEF_WIDTH-1:0]       r1_am, r1_bm, r1_cm;
    logic                        r1_sa, r1_sb, r1_sc;
    logic signed [NUM_WIDTH-1:0] r1_nb, r1_nc;
    logic [2*COEF_WIDTH-1:0]     r2_bb, r2_ac;
    logic [COEF_WIDTH-1:0]       r2_am, r2_bm;
    logic                        r2_sa, r2_sb, r2_sc;
    logic signed [NUM_WIDTH-1:0] r2_nb, r2_nc;
    logic                        adv;
    logic [DISC_WIDTH-1:0]       bb_w, ac4;
    logic                        ac_neg;
    t_job                        job;

    assign o_full     = r2_v && i_job_full;
    assign adv        = !o_full;
    assign o_job_push = r2_v && !i_job_full;
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_push;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_sa <= i_item.coef_square[COEF_WIDTH-1];
            r1_sb <= i_item.coef_linear[COEF_WIDTH-1];
            r1_sc <= i_item.coef_const[COEF_WIDTH-1];
            r1_am <= i_item.coef_square[COEF_WIDTH-1] ? -i_item.coef_square : i_item.coef_square;
            r1_bm <= i_item.coef_linear[COEF_WIDTH-1] ? -i_item.coef_linear : i_item.coef_linear;
            r1_cm <= i_item.coef_const[COEF_WIDTH-1] ? -i_item.coef_const : i_item.coef_const;
            r1_nb <= -$signed({{3{i_item.coef_linear[COEF_WIDTH-1]}}, i_item.coef_linear});
            r1_nc <= -$signed({{3{i_item.coef_const[COEF_WIDTH-1]}}, i_item.coef_const});
            r2_bb <= r1_bm * r1_bm;
            r2_ac <= r1_am * r1_cm;
            r2_am <= r1_am;
            r2_bm <= r1_bm;
            r2_sa <= r1_sa;
            r2_sb <= r1_sb;
            r2_sc <= r1_sc;
            r2_nb <= r1_nb;
            r2_nc <= r1_nc;
        end
    end

    always_comb begin
        bb_w   = {2'b00, r2_bb};
        ac4    = {r2_ac, 2'b00};
        ac_neg = (r2_sa != r2_sc) && (r2_ac != '0);
        job.disc    = '0;
        job.nbase   = r2_nb;
        job.den     = {r2_am, 1'b0};
        job.den_neg = r2_sa;
        job.kind    = K_NONE;
        if (r2_am == '0) begin
            job.nbase   = r2_nc;
            job.den     = {1'b0, r2_bm};
            job.den_neg = r2_sb;
            job.kind    = (r2_bm == '0) ? K_NONE : K_LIN;
        end else if (ac_neg) begin
            job.disc = bb_w + ac4;
            job.kind = K_TWO;
        end else if (bb_w < ac4) begin
            job.kind = K_NONE;
        end else begin
            job.disc = bb_w - ac4;
            job.kind = (job.disc == '0) ? K_DBL : K_TWO;
        end
    end

endmodule

// ===== src/qrs_fifo.sv =====
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module qrs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qrs_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output qrs_pkg::t_job o_data,
    output logic          o_empty
);
    import qrs_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_job              r_mem [FIFO_DEPTH];
    logic [PW-1:0]     r_wr, r_rd;
    logic [PW:0]       r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== src/qrs_back.sv =====
// Back end: pipelined square root, two pipelined dividers and the result register.
`timescale 1ns / 1ps
`include "quadratic_root_solver_core_assert.svh"
module qrs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qrs_pkg::t_job      i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    output qrs_pkg::t_out_item o_item,
    output logic               o_valid,
    input  logic               i_pop
);
    import qrs_pkg::*;

    localparam int SQ = SQRT_WIDTH;
    localparam int NM = DVD_WIDTH;

    function automatic t_sq sq_step(input t_sq s);
        t_sq                   r;
        logic [SQRT_WIDTH+1:0] rem2, trial;
        logic                  ge;
        r     = s;
        rem2  = {s.rem[SQRT_WIDTH-1:0], s.rad[DISC_WIDTH-1:DISC_WIDTH-2]};
        trial = {s.root, 2'b01};
        ge    = rem2 >= trial;
        r.rem  = ge ? rem2 - trial : rem2;
        r.root = {s.root[SQRT_WIDTH-2:0], ge};
        r.rad  = {s.rad[DISC_WIDTH-3:0], 2'b00};
        return r;
    endfunction

    function automatic t_lane dv_step(input t_lane l, input logic [DEN_WIDTH-1:0] den);
        t_lane              r;
        logic [DEN_WIDTH:0] rem2;
        logic               ge;
        r    = l;
        rem2 = {l.rem, l.dvd[NM-1]};
        ge   = rem2 >= {1'b0, den};
        rem2 = ge ? rem2 - {1'b0, den} : rem2;
        r.rem = rem2[DEN_WIDTH-1:0];
        r.quo = {l.quo[NM-2:0], ge};
        r.dvd = {l.dvd[NM-2:0], 1'b0};
        return r;
    endfunction

    function automatic t_lane lane_init(input logic signed [NUM_WIDTH-1:0] n,
                                        input logic den_neg);
        t_lane                r;
        logic [NUM_WIDTH-1:0] mag;
        mag   = n[NUM_WIDTH-1] ? NUM_WIDTH'(-n) : NUM_WIDTH'(n);
        r.dvd = {mag[NUM_WIDTH-2:0], {FRAC_BITS{1'b0}}};
        r.rem = '0;
        r.quo = '0;
        r.neg = n[NUM_WIDTH-1] != den_neg;
        return r;
    endfunction

    function automatic logic [COEF_WIDTH:0] lane_fin(input t_lane l);
        logic                  qneg, sat;
        logic [NM-1:0]         lim, mag;
        logic [COEF_WIDTH-1:0] v;
        qneg = l.neg && (l.quo != '0);
        lim  = qneg ? (NM'(1) << (COEF_WIDTH-1)) : ((NM'(1) << (COEF_WIDTH-1)) - NM'(1));
        sat  = l.quo > lim;
        mag  = sat ? lim : l.quo;
        v    = qneg ? -mag[COEF_WIDTH-1:0] : mag[COEF_WIDTH-1:0];
        return {sat, v};
    endfunction

    t_sq                   r_sq [SQ];
    logic [SQ-1:0]         r_sq_v;
    t_dv                   r_nm;
    logic                  r_nm_v;
    t_dv                   r_dv [NM];
    logic [NM-1:0]         r_dv_v;
    t_out_item             r_out, n_out;
    logic                  r_out_v;
    logic                  adv;
    t_sq                   sq_in;
    t_dv                   n_nm;
    logic signed [NUM_WIDTH-1:0] s_ext;
    logic [COEF_WIDTH:0]   f0, f1;

    assign adv       = !r_out_v || i_pop;
    assign o_job_pop = adv;
    assign o_item    = r_out;
    assign o_valid   = r_out_v;

    always_comb begin
        sq_in.job  = i_job;
        sq_in.rem  = '0;
        sq_in.root = '0;
        sq_in.rad  = i_job.disc;
    end

    always_comb begin
        s_ext     = $signed({{(NUM_WIDTH-SQRT_WIDTH){1'b0}}, r_sq[SQ-1].root});
        n_nm.kind = r_sq[SQ-1].job.kind;
        n_nm.den  = r_sq[SQ-1].job.den;
        if (r_sq[SQ-1].job.kind == K_TWO) begin
            n_nm.l0 = lane_init(r_sq[SQ-1].job.nbase + s_ext, r_sq[SQ-1].job.den_neg);
            n_nm.l1 = lane_init(r_sq[SQ-1].job.nbase - s_ext, r_sq[SQ-1].job.den_neg);
        end else begin
            n_nm.l0 = lane_init(r_sq[SQ-1].job.nbase, r_sq[SQ-1].job.den_neg);
            n_nm.l1 = lane_init('0, 1'b0);
        end
    end

    always_comb begin
        f0    = lane_fin(r_dv[NM-1].l0);
        f1    = lane_fin(r_dv[NM-1].l1);
        n_out = '0;
        case (r_dv[NM-1].kind)
            K_LIN, K_DBL: begin
                n_out.root_count = 2'd1;
                n_out.first_root = f0[COEF_WIDTH-1:0];
                n_out.saturated  = f0[COEF_WIDTH];
            end
            K_TWO: begin
                n_out.root_count  = 2'd2;
                n_out.first_root  = f0[COEF_WIDTH-1:0];
                n_out.second_root = f1[COEF_WIDTH-1:0];
                n_out.saturated   = f0[COEF_WIDTH] | f1[COEF_WIDTH];
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= '0;
            r_nm_v  <= 1'b0;
            r_dv_v  <= '0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_sq_v  <= {r_sq_v[SQ-2:0], !i_job_empty};
            r_nm_v  <= r_sq_v[SQ-1];
            r_dv_v  <= {r_dv_v[NM-2:0], r_nm_v};
            r_out_v <= r_dv_v[NM-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0] <= sq_step(sq_in);
            for (int k = 1; k < SQ; k++) begin
                r_sq[k] <= sq_step(r_sq[k-1]);
            end
            r_nm <= n_nm;
            r_dv[0].kind <= r_nm.kind;
            r_dv[0].den  <= r_nm.den;
            r_dv[0].l0   <= dv_step(r_nm.l0, r_nm.den);
            r_dv[0].l1   <= dv_step(r_nm.l1, r_nm.den);
            for (int k = 1; k < NM; k++) begin
                r_dv[k].kind <= r_dv[k-1].kind;
                r_dv[k].den  <= r_dv[k-1].den;
                r_dv[k].l0   <= dv_step(r_dv[k-1].l0, r_dv[k-1].den);
                r_dv[k].l1   <= dv_step(r_dv[k-1].l1, r_dv[k-1].den);
            end
            r_out <= n_out;
        end
    end

    `QRS_ASSERT_NOW(a_no_root_zero, r_out_v && r_out.root_count == 2'd0, r_out.first_root == '0 && r_out.second_root == '0 && !r_out.saturated, "Item without roots carries nonzero fields.")
    `QRS_ASSERT_NOW(a_second_zero, r_out_v && r_out.root_count != 2'd2, r_out.second_root == '0, "Second root set without two roots.")
    `QRS_ASSERT_NOW(a_count_range, r_out_v, r_out.root_count != 2'd3, "Root count out of range.")
    `QRS_ASSERT_NEXT(a_stall_hold, r_out_v && !i_pop, r_out_v && $stable(r_out_v), "Waiting result lost during a stall.")

endmodule
